@@ src/sre_pkg.sv @@
// Shared types, constants and constant functions for the sky radiance pipeline.
package sre_pkg;

  localparam int unsigned CHANNEL_WIDTH = 16;
  localparam logic [63:0] CHAN_MAX      = (64'd1 << CHANNEL_WIDTH) - 64'd1;

  localparam int unsigned SQ_STAGES  = 16;  // two root bits per stage, 31 bits
  localparam int unsigned DIV_STAGES = 8;   // two quotient bits per stage, 16 bits
  localparam int unsigned LOG_STEPS  = 16;  // one squaring per stage
  localparam int unsigned EXP_STEPS  = 16;  // one constant multiply per stage

  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } sre_in_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        clipped;
  } sre_out_t;

  typedef enum logic [2:0] {
    REG_ZENITH    = 3'd0,
    REG_HORIZON   = 3'd1,
    REG_GROUND    = 3'd2,
    REG_SUN_COLOR = 3'd3,
    REG_SUN_VEC   = 3'd4,
    REG_SHARP     = 3'd5,
    REG_INTENSITY = 3'd6
  } sre_reg_e;

  typedef struct packed {
    logic [47:0] zenith;
    logic [47:0] horizon;
    logic [47:0] ground;
    logic [47:0] sun_color;
    logic [47:0] sun_vec;
    logic [15:0] sharp;
    logic [15:0] intensity;
  } sre_cfg_t;

  // Sideband that rides along the lobe pipeline.
  typedef struct packed {
    logic [15:0] blend;
    logic        zen;
  } sre_tag_t;

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'd1 << 62;
    x = v;
    for (int n = 0; n < 32; n++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q.30 value of 2^(-2^-idx), built by repeated square roots from one half.
  function automatic logic [30:0] exp_const(int unsigned idx);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int unsigned i = 1; i <= idx; i++) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

@@ src/sre_cfg.sv @@
// APB register file holding colors, sun vector, sharpness and intensity.
module sre_cfg import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [5:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output sre_cfg_t    cfg_o
);

  sre_cfg_t cfg_q;
  logic     wr_en;

  assign wr_en = psel_i & penable_i & pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zenith    <= 48'd0;
      cfg_q.horizon   <= 48'd0;
      cfg_q.ground    <= 48'd0;
      cfg_q.sun_color <= 48'd0;
      cfg_q.sun_vec   <= 48'h0000_4000_0000;
      cfg_q.sharp     <= 16'd256;
      cfg_q.intensity <= 16'd256;
    end else if (wr_en) begin
      case (sre_reg_e'(paddr_i[5:3]))
        REG_ZENITH:    cfg_q.zenith    <= pwdata_i[47:0];
        REG_HORIZON:   cfg_q.horizon   <= pwdata_i[47:0];
        REG_GROUND:    cfg_q.ground    <= pwdata_i[47:0];
        REG_SUN_COLOR: cfg_q.sun_color <= pwdata_i[47:0];
        REG_SUN_VEC:   cfg_q.sun_vec   <= pwdata_i[47:0];
        REG_SHARP:     cfg_q.sharp     <= pwdata_i[15:0];
        REG_INTENSITY: cfg_q.intensity <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sre_reg_e'(paddr_i[5:3]))
      REG_ZENITH:    prdata_o = {16'd0, cfg_q.zenith};
      REG_HORIZON:   prdata_o = {16'd0, cfg_q.horizon};
      REG_GROUND:    prdata_o = {16'd0, cfg_q.ground};
      REG_SUN_COLOR: prdata_o = {16'd0, cfg_q.sun_color};
      REG_SUN_VEC:   prdata_o = {16'd0, cfg_q.sun_vec};
      REG_SHARP:     prdata_o = {48'd0, cfg_q.sharp};
      REG_INTENSITY: prdata_o = {48'd0, cfg_q.intensity};
      default:       prdata_o = 64'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/sre_norm.sv @@
// Vector normalizer: squares, pipelined square root, three pipelined dividers.
module sre_norm import sre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [2:0][15:0] vec_i,
  output logic             vld_o,
  output logic [2:0][16:0] unit_o
);

  typedef struct packed {
    logic [33:0]      rem;
    logic [30:0]      root;
    logic [31:0]      len;
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } sq_t;

  typedef struct packed {
    logic [2:0][46:0] rem;
    logic [2:0][15:0] q;
    logic [30:0]      s;
    logic [2:0]       neg;
    logic             zero;
  } dv_t;

  function automatic logic [1:0] get_pair(logic [31:0] l, int j);
    logic [1:0] p;
    p = 2'b00;
    if (j >= 15) p = l[2*j-30 +: 2];
    return p;
  endfunction

  // Stage 0: magnitudes and squares
  logic [2:0][31:0] n0_sq_q;
  logic [2:0][15:0] n0_mag_q;
  logic [2:0]       n0_neg_q;
  logic             n0_vld_q;
  logic [2:0][15:0] mag_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = vec_i[k][15] ? (~vec_i[k] + 16'd1) : vec_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n0_vld_q <= 1'b0;
    end else if (en_i) begin
      n0_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        n0_sq_q[k]  <= 32'(mag_d[k]) * 32'(mag_d[k]);
        n0_mag_q[k] <= mag_d[k];
        n0_neg_q[k] <= vec_i[k][15];
      end
    end
  end

  // Stage 1: squared length, then the root stages
  sq_t  st_q   [SQ_STAGES+1];
  logic st_vld [SQ_STAGES+1];
  logic [31:0] len_d;

  assign len_d = n0_sq_q[0] + n0_sq_q[1] + n0_sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld[0] <= 1'b0;
    end else if (en_i) begin
      st_vld[0] <= n0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].rem  <= 34'd0;
      st_q[0].root <= 31'd0;
      st_q[0].len  <= len_d;
      st_q[0].mag  <= n0_mag_q;
      st_q[0].neg  <= n0_neg_q;
      st_q[0].zero <= (len_d == 32'd0);
    end
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    sq_t nx;

    always_comb begin
      int         pj;
      logic [33:0] cur;
      logic [33:0] trial;
      logic [1:0]  pr;
      nx    = st_q[g];
      cur   = 34'd0;
      trial = 34'd0;
      pr    = 2'b00;
      for (int j = 0; j < 2; j++) begin
        pj = 30 - 2*g - j;
        if (pj >= 0) begin
          pr    = get_pair(nx.len, pj);
          cur   = {nx.rem[31:0], pr};
          trial = {1'b0, nx.root, 2'b01};
          if (cur >= trial) begin
            nx.rem  = cur - trial;
            nx.root = {nx.root[29:0], 1'b1};
          end else begin
            nx.rem  = cur;
            nx.root = {nx.root[29:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_vld[g+1] <= 1'b0;
      end else if (en_i) begin
        st_vld[g+1] <= st_vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[g+1] <= nx;
    end
  end

  // Divider stages: |c| * 2^30 / root, restoring, two bits per stage
  dv_t  dv_q   [DIV_STAGES];
  logic dv_vld [DIV_STAGES];
  dv_t  dv_init;
  sq_t  sq_last;

  assign sq_last = st_q[SQ_STAGES];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_init.rem[k] = {1'b0, sq_last.mag[k], 30'd0};
      dv_init.q[k]   = 16'd0;
    end
    dv_init.s    = sq_last.root;
    dv_init.neg  = sq_last.neg;
    dv_init.zero = sq_last.zero;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    dv_t  cur;
    dv_t  nx;
    logic cur_vld;

    if (g == 0) begin : g_first
      assign cur     = dv_init;
      assign cur_vld = st_vld[SQ_STAGES];
    end else begin : g_rest
      assign cur     = dv_q[g-1];
      assign cur_vld = dv_vld[g-1];
    end

    always_comb begin
      logic [46:0] sub;
      int          b;
      nx  = cur;
      sub = 47'd0;
      for (int j = 0; j < 2; j++) begin
        b   = 15 - 2*g - j;
        sub = 47'(nx.s) << b;
        for (int k = 0; k < 3; k++) begin
          if (nx.rem[k] >= sub) begin
            nx.rem[k]  = nx.rem[k] - sub;
            nx.q[k][b] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld[g] <= 1'b0;
      end else if (en_i) begin
        dv_vld[g] <= cur_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) dv_q[g] <= nx;
    end
  end

  dv_t dv_last;
  assign dv_last = dv_q[DIV_STAGES-1];
  assign vld_o   = dv_vld[DIV_STAGES-1];

  // zero-length input gives a zero vector
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_last.zero) begin
        unit_o[k] = 17'd0;
      end else if (dv_last.neg[k]) begin
        unit_o[k] = ~{1'b0, dv_last.q[k]} + 17'd1;
      end else begin
        unit_o[k] = {1'b0, dv_last.q[k]};
      end
    end
  end

endmodule

@@ src/sre_lobe.sv @@
// Sun lobe: cosine^sharpness as exp2(-sharpness * -log2(cosine)), pipelined.
module sre_lobe import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [15:0] cos_i,
  input  sre_tag_t    tag_i,
  input  logic [15:0] sharp_i,
  output logic        vld_o,
  output logic [15:0] lobe_o,
  output sre_tag_t    tag_o
);

  typedef struct packed {
    logic [15:0] m;
    logic [15:0] frac;
    logic [3:0]  sh;
    logic        zero;
    sre_tag_t    tag;
  } lg_t;

  typedef struct packed {
    logic [30:0] r;
    logic [27:0] e;
    logic        zero;
    sre_tag_t    tag;
  } ex_t;

  // Leading one: normalize the cosine to [1,2) in Q1.15
  lg_t  lg_q   [LOG_STEPS+1];
  logic lg_vld [LOG_STEPS+1];
  logic [3:0] lead;
  logic [3:0] sh_d;

  always_comb begin
    lead = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (cos_i[b]) lead = 4'(b);
    end
    sh_d = 4'd15 - lead;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_vld[0] <= 1'b0;
    end else if (en_i) begin
      lg_vld[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q[0].m    <= cos_i << sh_d;
      lg_q[0].frac <= 16'd0;
      lg_q[0].sh   <= sh_d;
      lg_q[0].zero <= (cos_i == 16'd0);
      lg_q[0].tag  <= tag_i;
    end
  end

  // One fraction bit of the logarithm per squaring
  for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
    lg_t         nx;
    logic [31:0] p;

    always_comb begin
      nx = lg_q[g];
      p  = 32'(lg_q[g].m) * 32'(lg_q[g].m);
      if (p[31]) begin
        nx.m    = p[31:16];
        nx.frac = {lg_q[g].frac[14:0], 1'b1};
      end else begin
        nx.m    = p[30:15];
        nx.frac = {lg_q[g].frac[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lg_vld[g+1] <= 1'b0;
      end else if (en_i) begin
        lg_vld[g+1] <= lg_vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) lg_q[g+1] <= nx;
    end
  end

  // Scale the log by the sharpness
  ex_t  ex_q   [EXP_STEPS+1];
  logic ex_vld [EXP_STEPS+1];
  lg_t         lg_last;
  logic [19:0] nlog;
  logic [35:0] scaled;

  assign lg_last = lg_q[LOG_STEPS];
  assign nlog    = {lg_last.sh, 16'd0} - {4'd0, lg_last.frac};
  assign scaled  = 36'(sharp_i) * 36'(nlog);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld[0] <= 1'b0;
    end else if (en_i) begin
      ex_vld[0] <= lg_vld[LOG_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ex_q[0].r    <= 31'h4000_0000;
      ex_q[0].e    <= scaled[35:8];
      ex_q[0].zero <= lg_last.zero;
      ex_q[0].tag  <= lg_last.tag;
    end
  end

  // Fraction of the exponent: multiply by 2^(-2^-i) for each set bit
  for (genvar g = 0; g < EXP_STEPS; g++) begin : g_exp
    localparam logic [30:0] Coef = exp_const(g + 1);
    ex_t         nx;
    logic [61:0] p;

    always_comb begin
      nx = ex_q[g];
      p  = 62'(ex_q[g].r) * 62'(Coef);
      if (ex_q[g].e[15-g]) nx.r = p[60:30];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ex_vld[g+1] <= 1'b0;
      end else if (en_i) begin
        ex_vld[g+1] <= ex_vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) ex_q[g+1] <= nx;
    end
  end

  // Integer part of the exponent: final right shift
  ex_t         ex_last;
  logic [11:0] kint;
  logic [15:0] lobe_d;
  logic        vld_q;
  logic [15:0] lobe_q;
  sre_tag_t    tag_q;

  assign ex_last = ex_q[EXP_STEPS];
  assign kint    = ex_last.e[27:16];

  always_comb begin
    if (sharp_i == 16'd0) begin
      lobe_d = ONE_Q15;
    end else if (ex_last.zero || kint >= 12'd31) begin
      lobe_d = 16'd0;
    end else begin
      lobe_d = 16'(ex_last.r >> (6'd15 + {1'b0, kint[4:0]}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= ex_vld[EXP_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lobe_q <= lobe_d;
      tag_q  <= ex_last.tag;
    end
  end

  assign vld_o  = vld_q;
  assign lobe_o = lobe_q;
  assign tag_o  = tag_q;

endmodule

@@ src/sre_shade.sv @@
// Channel shading: gradient blend plus sun lobe, intensity scale, saturation.
module sre_shade import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [15:0] lobe_i,
  input  sre_tag_t    tag_i,
  input  sre_cfg_t    cfg_i,
  output logic        vld_o,
  output sre_out_t    data_o
);

  // Stage A: products
  logic signed [2:0][33:0] pb_q;
  logic        [2:0][31:0] ps_q;
  logic        [2:0][15:0] h_q;
  logic                    a_vld_q;
  logic        [47:0]      endc;

  assign endc = tag_i.zen ? cfg_i.zenith : cfg_i.ground;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        pb_q[c] <= $signed({1'b0, endc[16*c +: 16]} - {1'b0, cfg_i.horizon[16*c +: 16]})
                 * $signed({1'b0, tag_i.blend});
        ps_q[c] <= 32'(cfg_i.sun_color[16*c +: 16]) * 32'(lobe_i);
        h_q[c]  <= cfg_i.horizon[16*c +: 16];
      end
    end
  end

  // Stage B: sum, never negative
  logic [2:0][32:0] acc_q;
  logic             b_vld_q;
  logic signed [34:0] acc_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_d[c] = $signed({4'd0, h_q[c], 15'd0}) + 35'($signed(pb_q[c]))
               + $signed({3'd0, ps_q[c]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) acc_q[c] <= acc_d[c][32:0];
    end
  end

  // Stage C: intensity
  logic [2:0][25:0] val_q;
  logic             c_vld_q;
  logic [48:0]      scl [3];

  always_comb begin
    for (int c = 0; c < 3; c++) scl[c] = 49'(acc_q[c]) * 49'(cfg_i.intensity);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) val_q[c] <= scl[c][48:23];
    end
  end

  // Stage D: saturate into the output register
  sre_out_t         out_d;
  sre_out_t         out_q;
  logic             out_vld_q;
  logic [2:0][15:0] chan;
  logic [2:0]       sat;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sat[c]  = 64'(val_q[c]) > CHAN_MAX;
      chan[c] = sat[c] ? CHAN_MAX[15:0] : val_q[c][15:0];
    end
    out_d.red     = chan[0];
    out_d.green   = chan[1];
    out_d.blue    = chan[2];
    out_d.clipped = |sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q   <= vld_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      out_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) out_q <= out_d;
  end

  assign vld_o  = out_vld_q;
  assign data_o = out_q;

endmodule

@@ src/sky_radiance_eval.sv @@
// Gradient sky with sun lobe, pipelined from request acceptance to out_valid_o.
// One request per cycle unless stalled; every stage advances together whenever the
// output register is empty or being taken, so in_ready_o follows that condition.
// The sun vector is normalized by a free-running copy of the same normalizer.
// Reset (rst_ni low, asynchronous) clears all valid bits and restores register defaults.
module sky_radiance_eval import sre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sre_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output sre_out_t    out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  sre_cfg_t cfg;
  logic     adv;
  logic     shd_vld;

  assign adv        = !shd_vld || out_ready_i;
  assign in_ready_o = adv;
  assign pready     = 1'b1;

  sre_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  logic [2:0][15:0] view_vec;
  logic [2:0][15:0] sun_vec;
  logic [2:0][16:0] d_unit;
  logic [2:0][16:0] s_unit;
  logic             d_vld;

  assign view_vec = {in_data_i.dir_z, in_data_i.dir_y, in_data_i.dir_x};
  assign sun_vec  = cfg.sun_vec;

  sre_norm u_norm_view (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (in_valid_i),
    .vec_i  (view_vec),
    .vld_o  (d_vld),
    .unit_o (d_unit)
  );

  // runs every cycle, never stalled; never behind any request that follows a write
  sre_norm u_norm_sun (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (1'b1),
    .vld_i  (1'b1),
    .vec_i  (sun_vec),
    .vld_o  (),
    .unit_o (s_unit)
  );

  // Dot-product terms and the blend square
  logic signed [2:0][33:0] prod_q;
  logic        [30:0]      tsq_q;
  logic                    zen_q;
  logic                    t0_vld_q;
  logic        [16:0]      up_abs;
  logic        [16:0]      tval;

  assign up_abs = d_unit[1][16] ? (~d_unit[1] + 17'd1) : d_unit[1];
  assign tval   = 17'd32768 - up_abs;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= $signed(d_unit[k]) * $signed(s_unit[k]);
      end
      tsq_q <= 31'(34'(tval) * 34'(tval));
      zen_q <= !d_unit[1][16];
    end
  end

  // Cosine and blend
  logic signed [35:0] dot;
  logic        [15:0] cos_d;
  logic        [15:0] cos_q;
  sre_tag_t           tag_d;
  sre_tag_t           tag_q;
  logic               t1_vld_q;

  assign dot = 36'($signed(prod_q[0])) + 36'($signed(prod_q[1]))
             + 36'($signed(prod_q[2]));

  always_comb begin
    if (dot[35] || dot == 36'sd0) begin
      cos_d = 16'd0;
    end else if (dot[35:15] > 21'd32768) begin
      cos_d = ONE_Q15;
    end else begin
      cos_d = dot[30:15];
    end
    tag_d.blend = 16'(17'd32768 - 17'(tsq_q >> 15));
    tag_d.zen   = zen_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q <= cos_d;
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_vld_q <= 1'b0;
      t1_vld_q <= 1'b0;
    end else if (adv) begin
      t0_vld_q <= d_vld;
      t1_vld_q <= t0_vld_q;
    end
  end

  logic        lobe_vld;
  logic [15:0] lobe;
  sre_tag_t    lobe_tag;

  sre_lobe u_lobe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .vld_i   (t1_vld_q),
    .cos_i   (cos_q),
    .tag_i   (tag_q),
    .sharp_i (cfg.sharp),
    .vld_o   (lobe_vld),
    .lobe_o  (lobe),
    .tag_o   (lobe_tag)
  );

  sre_shade u_shade (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (lobe_vld),
    .lobe_i (lobe),
    .tag_i  (lobe_tag),
    .cfg_i  (cfg),
    .vld_o  (shd_vld),
    .data_o (out_data_o)
  );

  assign out_valid_o = shd_vld;

endmodule

@@ src/sre_checker.sv @@
// Port-level checks for the sky radiance block, bound to the top level.
module sre_checker import sre_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sre_out_t out_data_o
);

  localparam logic [15:0] SatVal = CHAN_MAX[15:0];

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input request dropped before acceptance");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or vanished");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready not tied to output backpressure");

  a_clip_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      out_data_o.red == SatVal || out_data_o.green == SatVal
      || out_data_o.blue == SatVal)
    else $error("clipped set without a saturated channel");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind sky_radiance_eval sre_checker u_sre_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the sky radiance pipeline with its own bit-exact predictor.
`timescale 1ns / 100ps

module tb_top;
  import sre_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [15:0] x, y, z;
    bit                 known;
    sre_out_t           exp;
  } dir_row_t;

  localparam logic [2:0] REG_NONE   = 3'd7;   // unmapped register slot
  localparam int         DRAIN_WAIT = 120;    // longer than the pipeline
  localparam int         LIMIT      = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  sre_in_t     in_data = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  sre_out_t    out_data_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  sky_radiance_eval u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready_o), .in_data_i(in_data),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready), .out_data_o(out_data_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  // register mirror
  logic [47:0] sky_zen, sky_hor, sky_gnd, sky_sun, sky_svec;
  logic [15:0] sky_sharp, sky_gain;

  logic [63:0] half_pow [1:16];   // Q.30 of 2^(-2^-i)
  sre_out_t    radiance_q [$];
  int          n_bad = 0;
  int          n_checked = 0;
  int          n_sent = 0;
  int          n_phases = 0;
  int          cycles = 0;
  int          stall_left = 0;

  function automatic logic [63:0] root64(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input vec3_t c, output vec3_t n);
    logic [63:0] len2, s, mag, q;
    len2 = 0;
    for (int i = 0; i < 3; i++) len2 += c[i] * c[i];
    if (len2 == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return;
    end
    s = root64(len2 << 30);
    for (int i = 0; i < 3; i++) begin
      mag = (c[i] < 0) ? -c[i] : c[i];
      q = (mag << 30) / s;
      if (q > 32768) q = 32768;
      n[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  // -log2(v/32768) as Q.16
  function automatic logic [63:0] log2_mag(logic [63:0] v);
    int          e;
    logic [63:0] m, frac;
    e = 15;
    frac = 0;
    while (e > 0 && v[e] == 1'b0) e--;
    m = v << (15 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return 64'(15 - e) * 65536 - frac;
  endfunction

  function automatic logic [63:0] exp2_q15(logic [63:0] e);
    logic [63:0] k, r;
    k = e >> 16;
    r = 64'd1 << 30;
    for (int i = 1; i <= 16; i++)
      if (e[16-i]) r = (r * half_pow[i]) >> 30;
    if (k >= 31) return 0;
    return r >> (15 + k);
  endfunction

  function automatic sre_out_t sky_radiance(sre_in_t d);
    vec3_t       dv, sv, dn, sn;
    longint      up, t, blend, dot, acc, h, e, s;
    logic [63:0] cosv, lobe, value;
    logic [47:0] endc;
    sre_out_t    o;
    dv[0] = d.dir_x; dv[1] = d.dir_y; dv[2] = d.dir_z;
    sv[0] = $signed(sky_svec[15:0]);
    sv[1] = $signed(sky_svec[31:16]);
    sv[2] = $signed(sky_svec[47:32]);
    unit_vec(dv, dn);
    unit_vec(sv, sn);
    up = dn[1];
    t = 32768 - (up < 0 ? -up : up);
    blend = 32768 - ((t * t) >>> 15);
    endc = (up >= 0) ? sky_zen : sky_gnd;
    dot = dn[0] * sn[0] + dn[1] * sn[1] + dn[2] * sn[2];
    if (dot <= 0) cosv = 0;
    else begin
      cosv = dot >>> 15;
      if (cosv > 32768) cosv = 32768;
    end
    if (sky_sharp == 0) lobe = 32768;
    else if (cosv == 0) lobe = 0;
    else lobe = exp2_q15((64'(sky_sharp) * log2_mag(cosv)) >> 8);
    o = '0;
    for (int i = 0; i < 3; i++) begin
      h = sky_hor[16*i +: 16];
      e = endc[16*i +: 16];
      s = sky_sun[16*i +: 16];
      acc = h * 32768 + (e - h) * blend + s * longint'(lobe);
      if (acc < 0) acc = 0;
      value = (64'(acc) * sky_gain) >> 23;
      if (value > CHAN_MAX) begin
        value = CHAN_MAX;
        o.clipped = 1'b1;
      end
      case (i)
        0: o.red = value[15:0];
        1: o.green = value[15:0];
        default: o.blue = value[15:0];
      endcase
    end
    return o;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_ZENITH:    sky_zen = val[47:0];
      REG_HORIZON:   sky_hor = val[47:0];
      REG_GROUND:    sky_gnd = val[47:0];
      REG_SUN_COLOR: sky_sun = val[47:0];
      REG_SUN_VEC:   sky_svec = val[47:0];
      REG_SHARP:     sky_sharp = val[15:0];
      REG_INTENSITY: sky_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_sky(logic [47:0] zen, logic [47:0] hor, logic [47:0] gnd,
                         logic [47:0] sun, logic [47:0] svec, logic [15:0] sharp,
                         logic [15:0] gain);
    reg_write(REG_ZENITH, {16'h0, zen});
    reg_write(REG_HORIZON, {16'h0, hor});
    reg_write(REG_GROUND, {16'h0, gnd});
    reg_write(REG_SUN_COLOR, {16'h0, sun});
    reg_write(REG_SUN_VEC, {16'h0, svec});
    reg_write(REG_SHARP, {48'h0, sharp});
    reg_write(REG_INTENSITY, {48'h0, gain});
    // let the sun normalizer settle
    repeat (DRAIN_WAIT) @(posedge clk_i);
    n_phases++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // called at a rising edge; returns at the edge where the request is taken
  task automatic send_dir(sre_in_t d, bit known, sre_out_t exp, int gap);
    bit taken;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    radiance_q.push_back(known ? exp : sky_radiance(d));
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (radiance_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic sre_in_t rand_dir(int mode);
    sre_in_t     d;
    logic [15:0] ext [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    d.dir_x = $urandom;
    d.dir_y = $urandom;
    d.dir_z = $urandom;
    case (mode)
      0: d = '0;
      1: begin
        d.dir_x = ext[$urandom_range(0, 4)];
        d.dir_y = ext[$urandom_range(0, 4)];
        d.dir_z = ext[$urandom_range(0, 4)];
      end
      2: begin
        // aim close to the sun so the lobe is lit
        d.dir_x = $signed(sky_svec[15:0]) + $signed(16'($urandom_range(0, 2000)) - 16'sd1000);
        d.dir_y = $signed(sky_svec[31:16]) + $signed(16'($urandom_range(0, 2000)) - 16'sd1000);
        d.dir_z = $signed(sky_svec[47:32]) + $signed(16'($urandom_range(0, 2000)) - 16'sd1000);
      end
      3: begin
        d.dir_x = $signed(16'($urandom_range(0, 15))) - 16'sd8;
        d.dir_y = $signed(16'($urandom_range(0, 15))) - 16'sd8;
        d.dir_z = $signed(16'($urandom_range(0, 15))) - 16'sd8;
      end
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [47:0] rand_color();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return {$urandom, $urandom} & 48'h01FF_01FF_01FF;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] rand_sharp();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0100;
      3: return 16'($urandom);
      default: return 16'($urandom_range(1, 16'h0C00));
    endcase
  endfunction

  // sink side: random stalls, now and then a long one
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 8) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // outputs and ready only move at rising edges, so mid-cycle sampling is stable
  always @(negedge clk_i) begin
    sre_out_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (radiance_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", out_data_o);
      end else begin
        want = radiance_q.pop_front();
        n_checked++;
        if (out_data_o !== want) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch #%0d: rgb exp %h %h %h clip %b, got %h %h %h clip %b",
                     n_checked, want.red, want.green, want.blue, want.clipped,
                     out_data_o.red, out_data_o.green, out_data_o.blue,
                     out_data_o.clipped);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t    rows [$];
    sre_out_t    zero_out, sat_out;
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) begin
      c = root64(c << 30);
      half_pow[i] = c;
    end
    sky_zen = '0; sky_hor = '0; sky_gnd = '0; sky_sun = '0;
    sky_svec = 48'h0000_4000_0000;
    sky_sharp = 16'h0100;
    sky_gain = 16'h0100;
    zero_out = '0;
    sat_out = '{red: 16'hFFFF, green: 16'hFFFF, blue: 16'hFFFF, clipped: 1'b1};

    rows = '{
      '{16'sh0000, 16'sh0000, 16'sh0000, 1'b1, zero_out},   // zero direction
      '{16'sh0000, 16'sh4000, 16'sh0000, 1'b1, zero_out},   // straight up
      '{16'sh0000, -16'sh4000, 16'sh0000, 1'b1, zero_out},  // straight down
      '{16'sh4000, 16'sh0000, 16'sh0000, 1'b1, zero_out},   // horizon
      '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, zero_out},
      '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b1, zero_out},
      '{-16'sh8000, 16'sh7FFF, 16'sh0000, 1'b1, zero_out},
      '{16'sh0001, 16'sh0000, 16'sh0000, 1'b1, zero_out},
      '{16'sh0000, -16'sh0001, 16'sh0000, 1'b1, zero_out},
      '{16'sh0000, 16'sh0000, -16'sh8000, 1'b1, zero_out},
      '{16'sh1000, 16'sh3000, -16'sh2000, 1'b0, zero_out},
      '{-16'sh5555, 16'sh0100, 16'sh2AAA, 1'b0, zero_out},
      '{16'sh0000, 16'sh7FFF, 16'sh0001, 1'b0, zero_out},
      '{16'sh0003, -16'sh0004, 16'sh0000, 1'b0, zero_out}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // reset settings give black everywhere
    foreach (rows[i])
      send_dir('{rows[i].x, rows[i].y, rows[i].z}, rows[i].known, zero_out, pick_gap());
    drain();

    // everything at full scale saturates every channel
    set_sky('1, '1, '1, '1, 48'h0000_4000_0000, 16'h0000, 16'hFFFF);
    foreach (rows[i])
      send_dir('{rows[i].x, rows[i].y, rows[i].z}, 1'b1, sat_out, pick_gap());
    drain();

    // sunny sky, then flat lobe, an ignored register write and no sun
    set_sky(48'h0080_0060_0040, 48'h0100_00E0_00C0, 48'h0030_0040_0050,
            48'h0200_0200_0180, 48'h2000_3000_1000, 16'h0800, 16'h0100);
    foreach (rows[i])
      send_dir('{rows[i].x, rows[i].y, rows[i].z}, 1'b0, zero_out, pick_gap());
    drain();
    reg_write(REG_SHARP, 64'h0);
    reg_write(REG_NONE, '1);
    reg_write(REG_SUN_VEC, 64'h0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    foreach (rows[i])
      send_dir('{rows[i].x, rows[i].y, rows[i].z}, 1'b0, zero_out, pick_gap());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      logic [47:0] sv;
      case ($urandom_range(0, 4))
        0: sv = '0;
        1: sv = 48'h0000_4000_0000;
        default: sv = {$urandom, $urandom};
      endcase
      set_sky(rand_color(), rand_color(), rand_color(), rand_color(), sv, rand_sharp(),
              ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16'h0200)));
      for (int k = 0; k < 235; k++) begin
        int p, m;
        p = $urandom_range(0, 99);
        m = (p < 3) ? 0 : (p < 13) ? 1 : (p < 43) ? 2 : (p < 48) ? 3 : 4;
        // runs without gaps in one part of each phase
        send_dir(rand_dir(m), 1'b0, zero_out, (k > 100 && k < 140) ? 0 : pick_gap());
      end
      drain();
    end

    $display("sent %0d view directions over %0d register settings, %0d results checked",
             n_sent, n_phases, n_checked);
    if (n_bad == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
